// ===== hw/rtl/nts_pkg.sv =====
// Shared types and constants for the next-hop threshold selector.
// Used by the tracker, the result register and the top level; no dependencies.
package nts_pkg;

  typedef enum logic [1:0] {
    REG_MODE_MASK       = 2'd0,
    REG_DELAY_LIMIT     = 2'd1,
    REG_LOSS_LIMIT      = 2'd2,
    REG_BANDWIDTH_LIMIT = 2'd3
  } reg_idx_t;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned VAL_IN_W   = 32;
  localparam int unsigned LOSS_W     = 16;
  localparam int unsigned OUT_FACE_W = 16;

  localparam logic [2:0]        MODE_RESET      = 3'd1;
  localparam logic [31:0]       DELAY_LIM_RESET = 32'd100000;
  localparam logic [LOSS_W-1:0] LOSS_LIM_RESET  = 16'hFFFF;
  localparam logic [31:0]       BW_LIM_RESET    = 32'd0;

  typedef struct packed {
    logic [OUT_FACE_W-1:0] chosen_face;
    logic                  face_found;
  } res_t;

endpackage

// ===== hw/rtl/nts_in_reg.sv =====
// Input register stage of the next-hop threshold selector.
// Holds one candidate hop until the tracker consumes it; no package dependencies.
module nts_in_reg #(
  parameter int unsigned FACE_ID_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic                     take,
  input  logic [FACE_ID_WIDTH-1:0] face_id,
  input  logic [31:0]              delay_us,
  input  logic [15:0]              loss_frac,
  input  logic [31:0]              bandwidth_bps,
  input  logic                     can_forward,
  input  logic                     last_hop,
  output logic                     valid,
  output logic [FACE_ID_WIDTH-1:0] face_id_q,
  output logic [31:0]              delay_us_q,
  output logic [15:0]              loss_frac_q,
  output logic [31:0]              bandwidth_bps_q,
  output logic                     can_forward_q,
  output logic                     last_hop_q
);

  logic valid_r;
  logic valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      face_id_q       <= face_id;
      delay_us_q      <= delay_us;
      loss_frac_q     <= loss_frac;
      bandwidth_bps_q <= bandwidth_bps;
      can_forward_q   <= can_forward;
      last_hop_q      <= last_hop;
    end
  end

  assign valid = valid_r;

endmodule

// ===== hw/rtl/nts_tracker.sv =====
// Limit registers, per-request candidate trackers and working face.
// Evaluates one hop per step and forms the request result; uses nts_pkg.
module nts_tracker #(
  parameter int unsigned FACE_ID_WIDTH = 16,
  parameter int unsigned VALUE_WIDTH   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [nts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nts_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             step,
  input  logic [FACE_ID_WIDTH-1:0]         face_id,
  input  logic [31:0]                      delay_us,
  input  logic [15:0]                      loss_frac,
  input  logic [31:0]                      bandwidth_bps,
  input  logic                             can_forward,
  input  logic                             last_hop,
  output nts_pkg::res_t                    res
);

  localparam int unsigned VM = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned CW = ((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32) + 3;

  logic [2:0]                mode_r;
  logic [31:0]               delay_lim_r;
  logic [15:0]               loss_lim_r;
  logic [31:0]               bw_lim_r;
  logic [FACE_ID_WIDTH-1:0]  working_face_r;
  logic                      working_valid_r;
  logic [FACE_ID_WIDTH-1:0]  both_face_r, both_face_nxt;
  logic                      both_valid_r, both_valid_nxt;
  logic [FACE_ID_WIDTH-1:0]  single_face_r, single_face_nxt;
  logic                      single_valid_r, single_valid_nxt;
  logic [VALUE_WIDTH-1:0]    best_value_r, best_value_nxt;
  logic [FACE_ID_WIDTH-1:0]  best_face_r, best_face_nxt;
  logic                      best_valid_r, best_valid_nxt;

  logic [VALUE_WIDTH-1:0]    delay_v;
  logic [VALUE_WIDTH-1:0]    bw_v;
  logic [VALUE_WIDTH-1:0]    v_sel;
  logic [31:0]               lim_sel;
  logic                      up;
  logic                      is_working;
  logic                      both_mode;
  logic                      any_mode;
  logic                      hit;
  logic                      both_ok;
  logic                      single_ok;
  logic                      better;
  logic                      found;
  logic [FACE_ID_WIDTH-1:0]  chosen;

  // Hops other than the working face must beat the limit by a factor of 1.2.
  function automatic logic meets(input logic [CW-1:0] v, input logic [CW-1:0] lim,
                                 input logic working, input logic upward);
    logic [CW-1:0] v5, v6, l5, l6;
    v5 = (v << 2) + v;
    v6 = (v << 2) + (v << 1);
    l5 = (lim << 2) + lim;
    l6 = (lim << 2) + (lim << 1);
    if (working) begin
      meets = upward ? (v > lim) : (v < lim);
    end else begin
      meets = upward ? (v5 > l6) : (v6 < l5);
    end
  endfunction

  assign delay_v    = VALUE_WIDTH'(delay_us[VM-1:0]);
  assign bw_v       = VALUE_WIDTH'(bandwidth_bps[VM-1:0]);
  assign is_working = working_valid_r && (face_id == working_face_r);
  assign both_mode  = (mode_r[1:0] == 2'b11);
  assign any_mode   = |mode_r;
  assign hit        = can_forward && any_mode;

  always_comb begin
    if (mode_r[0]) begin
      v_sel   = delay_v;
      lim_sel = delay_lim_r;
      up      = 1'b0;
    end else if (mode_r[1]) begin
      v_sel   = VALUE_WIDTH'(loss_frac);
      lim_sel = 32'(loss_lim_r);
      up      = 1'b0;
    end else begin
      v_sel   = bw_v;
      lim_sel = bw_lim_r;
      up      = 1'b1;
    end
  end

  assign both_ok   = meets(CW'(delay_v), CW'(delay_lim_r), is_working, 1'b0)
                  && meets(CW'(loss_frac), CW'(loss_lim_r), is_working, 1'b0);
  assign single_ok = meets(CW'(v_sel), CW'(lim_sel), is_working, up);
  assign better    = up ? (v_sel > best_value_r) : (v_sel < best_value_r);

  always_comb begin
    both_face_nxt    = both_face_r;
    both_valid_nxt   = both_valid_r;
    single_face_nxt  = single_face_r;
    single_valid_nxt = single_valid_r;
    best_value_nxt   = best_value_r;
    best_face_nxt    = best_face_r;
    best_valid_nxt   = best_valid_r;
    if (hit) begin
      if (both_mode && !both_valid_r && both_ok) begin
        both_face_nxt  = face_id;
        both_valid_nxt = 1'b1;
      end
      if (!single_valid_r && single_ok) begin
        single_face_nxt  = face_id;
        single_valid_nxt = 1'b1;
      end
      if (!best_valid_r || better) begin
        best_value_nxt = v_sel;
        best_face_nxt  = face_id;
        best_valid_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    found  = 1'b0;
    chosen = '0;
    if (any_mode) begin
      if (both_mode && both_valid_nxt) begin
        found  = 1'b1;
        chosen = both_face_nxt;
      end else if (single_valid_nxt) begin
        found  = 1'b1;
        chosen = single_face_nxt;
      end else if (best_valid_nxt) begin
        found  = 1'b1;
        chosen = best_face_nxt;
      end
    end
  end

  assign res.chosen_face = nts_pkg::OUT_FACE_W'(chosen);
  assign res.face_found  = found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= nts_pkg::MODE_RESET;
      delay_lim_r     <= nts_pkg::DELAY_LIM_RESET;
      loss_lim_r      <= nts_pkg::LOSS_LIM_RESET;
      bw_lim_r        <= nts_pkg::BW_LIM_RESET;
      working_valid_r <= 1'b0;
      both_valid_r    <= 1'b0;
      single_valid_r  <= 1'b0;
      best_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (nts_pkg::reg_idx_t'(cfg_index))
          nts_pkg::REG_MODE_MASK:       mode_r      <= cfg_wdata[2:0];
          nts_pkg::REG_DELAY_LIMIT:     delay_lim_r <= cfg_wdata[31:0];
          nts_pkg::REG_LOSS_LIMIT:      loss_lim_r  <= cfg_wdata[15:0];
          nts_pkg::REG_BANDWIDTH_LIMIT: bw_lim_r    <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (step) begin
        if (last_hop) begin
          both_valid_r   <= 1'b0;
          single_valid_r <= 1'b0;
          best_valid_r   <= 1'b0;
          if (found) begin
            working_valid_r <= 1'b1;
          end
        end else begin
          both_valid_r   <= both_valid_nxt;
          single_valid_r <= single_valid_nxt;
          best_valid_r   <= best_valid_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      both_face_r   <= both_face_nxt;
      single_face_r <= single_face_nxt;
      best_value_r  <= best_value_nxt;
      best_face_r   <= best_face_nxt;
      if (last_hop && found) begin
        working_face_r <= chosen;
      end
    end
  end

endmodule

// ===== hw/rtl/nts_out_reg.sv =====
// Result register of the next-hop threshold selector.
// Holds one result until the receiver takes it; uses nts_pkg::res_t.
module nts_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  nts_pkg::res_t                   res,
  output logic                            free,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [nts_pkg::OUT_FACE_W-1:0]  out_tdata,
  output logic                            out_tuser
);

  logic          valid_r;
  logic          valid_nxt;
  nts_pkg::res_t res_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.chosen_face;
  assign out_tuser  = res_r.face_found;

endmodule

// ===== hw/rtl/nexthop_threshold_selector.sv =====
// Top level of the next-hop threshold selector.
// Instantiates nts_in_reg, nts_tracker and nts_out_reg; uses nts_pkg.
//
// Usage. Candidate hops of one request arrive on the in_ stream, one per
// transfer; in_tlast marks the final hop of the request and in_tuser carries
// the can-forward flag. For each request exactly one result leaves on the
// out_ stream after its last hop: the chosen face in out_tdata and the
// found flag in out_tuser. Hops that are not last produce no result.
// Limits and the mode mask are written through the cfg_ port while the
// block is idle.
// Throughput is one hop per cycle, except while a last hop waits for a
// stalled result register. A hop passes the input register and is then
// evaluated by the tracker into the result register, and out_tvalid rises
// once the result of its last hop is loaded there.
// When the receiver stalls, the result is held and the input register keeps
// accepting hops that are not last; a last hop waits in the input register
// until the result register frees, and in_tready drops behind it.
// Reset clears the valid flags, the trackers and the working-face valid flag,
// and loads the reset values of the mode mask and the limit registers.
module nexthop_threshold_selector #(
  parameter int unsigned FACE_ID_WIDTH = 16,
  parameter int unsigned VALUE_WIDTH   = 32,
  localparam int unsigned IN_DW = ((FACE_ID_WIDTH + 80 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // face_id, delay_us, loss_frac, bandwidth_bps, zero padding
  input  logic [IN_DW-1:0]                in_tdata,
  // can_forward
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // chosen_face
  output logic [nts_pkg::OUT_FACE_W-1:0]  out_tdata,
  // face_found
  output logic                            out_tuser
);

  localparam int unsigned FW = FACE_ID_WIDTH;

  logic          s1_valid;
  logic          s1_go;
  logic          in_load;
  logic          out_free;
  logic [FW-1:0] s1_face;
  logic [31:0]   s1_delay;
  logic [15:0]   s1_loss;
  logic [31:0]   s1_bw;
  logic          s1_fwd;
  logic          s1_last;
  nts_pkg::res_t res;

  assign s1_go     = s1_valid && (!s1_last || out_free);
  assign in_tready = !s1_valid || s1_go;
  assign in_load   = in_tvalid && in_tready;

  nts_in_reg #(
    .FACE_ID_WIDTH(FACE_ID_WIDTH)
  ) u_in_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (in_load),
    .take            (s1_go),
    .face_id         (in_tdata[FW-1:0]),
    .delay_us        (in_tdata[FW+31:FW]),
    .loss_frac       (in_tdata[FW+47:FW+32]),
    .bandwidth_bps   (in_tdata[FW+79:FW+48]),
    .can_forward     (in_tuser),
    .last_hop        (in_tlast),
    .valid           (s1_valid),
    .face_id_q       (s1_face),
    .delay_us_q      (s1_delay),
    .loss_frac_q     (s1_loss),
    .bandwidth_bps_q (s1_bw),
    .can_forward_q   (s1_fwd),
    .last_hop_q      (s1_last)
  );

  nts_tracker #(
    .FACE_ID_WIDTH(FACE_ID_WIDTH),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .step          (s1_go),
    .face_id       (s1_face),
    .delay_us      (s1_delay),
    .loss_frac     (s1_loss),
    .bandwidth_bps (s1_bw),
    .can_forward   (s1_fwd),
    .last_hop      (s1_last),
    .res           (res)
  );

  nts_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_go && s1_last),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_no_face_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("result without a face carries a nonzero face id");

  a_last_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && s1_last && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while a last hop is blocked");

  a_held_hop_stable : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_face) && $stable(s1_last)))
    else $error("held hop was lost or overwritten");

  a_result_follows_last : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last) |=> out_tvalid)
    else $error("last hop produced no result");

endmodule
